@@ rtl/vilri_pkg.sv @@
package vilri_pkg;

  localparam int LR_W = 64;

  localparam logic [1:0] KIND_INJECT = 2'd0;
  localparam logic [1:0] KIND_CLEAR  = 2'd1;
  localparam logic [1:0] KIND_QUERY  = 2'd2;

  localparam logic [1:0] ST_DONE   = 2'd0;
  localparam logic [1:0] ST_EXISTS = 2'd1;
  localparam logic [1:0] ST_BUSY   = 2'd2;

  localparam int LR_GROUP1_BIT  = 60;
  localparam int LR_HW_BIT      = 61;
  localparam int LR_PENDING_BIT = 62;
  localparam int LR_PHYS_SHIFT  = 32;

  localparam logic [9:0] SGI_LIMIT     = 10'd16;
  localparam logic [4:0] NUM_LRS_RESET = 5'd4;

  function automatic logic [LR_W-1:0] lr_word(input logic [9:0] id);
    logic [LR_W-1:0] w;
    w = LR_W'(id);
    w[LR_GROUP1_BIT]  = 1'b1;
    w[LR_PENDING_BIT] = 1'b1;
    if (id >= SGI_LIMIT) begin
      w[LR_HW_BIT] = 1'b1;
      w[LR_PHYS_SHIFT +: 10] = id;
    end
    return w;
  endfunction

endpackage

@@ rtl/vilri_lr_store.sv @@
module vilri_lr_store
  import vilri_pkg::*;
#(
  parameter int DEPTH = 16,
  parameter int AW    = 4
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            clr,
  input  logic            wr_en,
  input  logic [AW-1:0]   wr_addr,
  input  logic [LR_W-1:0] wr_data,
  input  logic            rd_en,
  input  logic [AW-1:0]   rd_addr,
  output logic [LR_W-1:0] rd_data
);

  logic [LR_W-1:0] mem [DEPTH];
  logic [DEPTH-1:0] valid;
  logic [LR_W-1:0] rdata;
  logic            rvalid;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rdata <= mem[rd_addr];
    end
  end

  // valid bits stand in for the all-zero reset and clear of the file
  always_ff @(posedge clk) begin
    if (rst || clr) begin
      valid  <= '0;
      rvalid <= 1'b0;
    end else begin
      if (wr_en) begin
        valid[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rvalid <= valid[rd_addr];
      end
    end
  end

  assign rd_data = rvalid ? rdata : '0;

endmodule

@@ rtl/virtual_irq_list_register_injector.sv @@
// List register injector. Assert start while busy is low to hand in an item;
// the block then holds busy high until the result is out. Inject and query
// items scan the slots in use one per cycle through the single read port of
// the list register memory, min(num_lrs, MAX_LRS) slots in all; clear, unused
// kinds and num_lrs of zero skip the scan. The result is shown for exactly
// one cycle with done high and cannot be held off, so the receiver must take
// it then. A new item may be started in the result cycle. The user must write
// num_lrs through cfg_we/cfg_data only while no item is in progress; the block
// itself does not enforce this.
module virtual_irq_list_register_injector
  import vilri_pkg::*;
#(
  parameter int MAX_LRS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [4:0]  cfg_data,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  kind,
  input  logic [9:0]  irq_id,
  input  logic [15:0] empty_mask,
  output logic        done,
  output logic [1:0]  status,
  output logic [3:0]  slot,
  output logic [63:0] entry_word,
  output logic        any_pending
);

  localparam int IW = (MAX_LRS > 1) ? $clog2(MAX_LRS) : 1;
  localparam int CW = $clog2(MAX_LRS + 1);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_SCAN  = 2'd1;
  localparam logic [1:0] S_DRAIN = 2'd2;
  localparam logic [1:0] S_FIN   = 2'd3;

  logic [1:0]      state;
  logic [4:0]      num_lrs;
  logic [1:0]      kind_r;
  logic [9:0]      id_r;
  logic [15:0]     mask_r;
  logic [CW-1:0]   n_r;
  logic [CW-1:0]   idx;
  logic            chk_valid;
  logic [IW-1:0]   chk_idx;
  logic            exists;
  logic            found;
  logic [IW-1:0]   free_slot;
  logic            pend;

  logic [CW-1:0]   n_in_use;
  logic [LR_W-1:0] rd_word;
  logic [LR_W-1:0] new_word;
  logic            rd_en;
  logic            wr_en;
  logic            clr;

  assign n_in_use = (num_lrs > 5'(MAX_LRS)) ? CW'(MAX_LRS) : num_lrs[CW-1:0];
  assign new_word = lr_word(id_r);
  assign busy     = (state != S_IDLE);
  assign rd_en    = (state == S_SCAN);
  assign wr_en    = (state == S_FIN) && (kind_r == KIND_INJECT) && !exists && found;
  assign clr      = (state == S_FIN) && (kind_r == KIND_CLEAR);

  vilri_lr_store #(
    .DEPTH (MAX_LRS),
    .AW    (IW)
  ) u_store (
    .clk     (clk),
    .rst     (rst),
    .clr     (clr),
    .wr_en   (wr_en),
    .wr_addr (free_slot),
    .wr_data (new_word),
    .rd_en   (rd_en),
    .rd_addr (idx[IW-1:0]),
    .rd_data (rd_word)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      num_lrs   <= NUM_LRS_RESET;
      done      <= 1'b0;
      chk_valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        num_lrs <= cfg_data;
      end
      done      <= 1'b0;
      chk_valid <= (state == S_SCAN);
      unique case (state)
        S_IDLE: begin
          if (start) begin
            kind_r <= kind;
            id_r   <= irq_id;
            mask_r <= empty_mask;
            n_r    <= n_in_use;
            idx    <= '0;
            if ((kind == KIND_INJECT || kind == KIND_QUERY) && n_in_use != '0) begin
              state <= S_SCAN;
            end else begin
              state <= S_FIN;
            end
          end
        end
        S_SCAN: begin
          idx <= idx + CW'(1);
          if (idx == n_r - CW'(1)) begin
            state <= S_DRAIN;
          end
        end
        S_DRAIN: begin
          state <= S_FIN;
        end
        S_FIN: begin
          done  <= 1'b1;
          state <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // slot compare, one read result per cycle
  always_ff @(posedge clk) begin
    chk_idx <= idx[IW-1:0];
    if (state == S_IDLE) begin
      exists    <= 1'b0;
      found     <= 1'b0;
      free_slot <= '0;
      pend      <= 1'b0;
    end else if (chk_valid) begin
      if (mask_r[chk_idx]) begin
        if (!found) begin
          found     <= 1'b1;
          free_slot <= chk_idx;
        end
      end else if (rd_word[31:0] == 32'(id_r)) begin
        exists <= 1'b1;
      end
      if (rd_word[LR_PENDING_BIT]) begin
        pend <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_FIN) begin
      status      <= ST_DONE;
      slot        <= '0;
      entry_word  <= '0;
      any_pending <= 1'b0;
      case (kind_r)
        KIND_INJECT: begin
          if (exists) begin
            status <= ST_EXISTS;
          end else if (!found) begin
            status <= ST_BUSY;
          end else begin
            slot       <= 4'(free_slot);
            entry_word <= new_word;
          end
        end
        KIND_QUERY: begin
          any_pending <= pend;
        end
        default: begin
        end
      endcase
    end
  end

  a_done_after_work: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(state) == S_FIN)
    else $error("result strobe without a finished item");

  a_start_takes: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy)
    else $error("accepted item did not raise busy");

  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    done && status != ST_DONE |-> slot == '0 && entry_word == '0 && !any_pending)
    else $error("failed inject carries payload");

  a_pend_query: assert property (@(posedge clk) disable iff (rst)
    done && any_pending |-> status == ST_DONE && entry_word == '0)
    else $error("pending answer on a non-query result");

  a_write_done: assert property (@(posedge clk) disable iff (rst)
    wr_en |=> done && status == ST_DONE && entry_word[LR_PENDING_BIT])
    else $error("slot write without matching result");

endmodule
